FILE: rtl/core/tltw_pkg.sv
// package for the two-level timing wheel: types, codes and constants
`default_nettype none
package tltw_pkg;
    localparam int MAX_TASKS_DEF = 16;
    localparam int SLOTS_DEF     = 10;
    localparam int MAX_RESULTS   = 16;
    localparam int NRES_W        = 5;
    localparam int TICKS_PER_SEC = 10;
    localparam int FAST_LIMIT    = 1000;
    // t / 100 for t < 1000 is (t * 656) >> 16
    localparam int RECIP_100     = 656;
    localparam int SHIFT_100     = 16;
    // t / 1000 for any 16-bit t is (t * 67109) >> 26
    localparam int RECIP_1000    = 67109;
    localparam int SHIFT_1000    = 26;
    localparam int SUM_W         = 8;

    typedef enum logic [1:0] {
        ST_FIRED   = 2'd0,
        ST_ADD_OK  = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_FIRE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRE_HEAD,
        S_FIRE,
        S_REARM,
        S_CALC,
        S_MOD,
        S_WALK_INIT,
        S_WALK,
        S_AFTER,
        S_EMIT,
        S_FIN
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/two_level_timing_wheel.sv
// two-level timing wheel: task pool, slot lists and firing sequencer
// an add computes its slot index, reduces it modulo the slot count and walks its slot
//   to its sorted place; a rejected add only emits its status; a tick fires the current
//   fast slot, then re-files each re-armed entry in firing order; every tenth tick also
//   fires the slow slot; a stalled result channel holds the transaction back
// throughput: one transaction at a time, ready only in idle with no result pending
// reset: synchronous active low; clears pool valid bits, slot heads, pointers, tick count
`default_nettype none
module two_level_timing_wheel #(
    parameter int MAX_TASKS = tltw_pkg::MAX_TASKS_DEF,
    parameter int SLOTS     = tltw_pkg::SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [15:0]        i_task_id,
    input  wire logic [15:0]        i_timeout_ms,
    input  wire logic               i_periodic,
    input  wire logic signed [15:0] i_repeat_count,
    input  wire logic [15:0]        i_interval_ms,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_fired_task_id,
    output logic [1:0]              o_status,
    output logic                    o_last
);
    import tltw_pkg::*;

    localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PW  = IW + 1;                 // entry pointer, top bit = empty marker
    localparam int SPW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SXW = $clog2(2 * SLOTS);
    localparam int KW  = $clog2(MAX_TASKS + 1);
    localparam logic [PW-1:0] NIL = {1'b1, {IW{1'b0}}};

    // pool, payload fields (written before any read)
    logic [15:0]        r_id       [MAX_TASKS];
    logic [15:0]        r_timeout  [MAX_TASKS];
    logic [15:0]        r_interval [MAX_TASKS];
    logic signed [15:0] r_repeat   [MAX_TASKS];
    logic               r_periodic [MAX_TASKS];
    logic [PW-1:0]      r_next     [MAX_TASKS];
    // re-arm queue: entry and its new timeout, in firing order
    logic [IW-1:0]      r_rq       [MAX_TASKS];
    logic [15:0]        r_rqt      [MAX_TASKS];

    // control state
    logic [MAX_TASKS-1:0] r_valid;
    logic [PW-1:0]        r_head [2*SLOTS];
    logic [SPW-1:0]       r_fp, r_sp;
    logic [3:0]           r_tc;
    t_state               r_state, n_state;
    logic                 r_tick, r_second, r_slowph, r_slow;
    t_status              r_est;
    logic [IW-1:0]        r_e;
    logic [15:0]          r_t;
    logic [SXW-1:0]       r_slot;
    logic [PW-1:0]        r_cur, r_prev;
    logic [KW-1:0]        r_k, r_ri;
    logic [SUM_W-1:0]     r_sum;
    logic [NRES_W-1:0]    r_nres;

    // pending result and output register
    logic        r_pv, r_ov, r_olast;
    logic [15:0] r_pid, r_oid;
    t_status     r_pst, r_ost;

    assign o_ready         = (r_state == S_IDLE) && !r_pv;
    assign o_valid         = r_ov;
    assign o_fired_task_id = r_oid;
    assign o_status        = r_ost;
    assign o_last          = r_olast;

    logic w_acc;
    assign w_acc = i_valid && o_ready;

    // lowest free pool entry
    logic          w_full;
    logic [IW-1:0] w_free;
    always_comb begin
        w_full = 1'b1;
        w_free = '0;
        for (int j = MAX_TASKS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                w_full = 1'b0;
                w_free = IW'(j);
            end
        end
    end

    // entry at the walk pointer
    logic          w_cur_nil;
    logic [IW-1:0] w_ci;
    logic          w_rearm, w_walk_on;
    assign w_cur_nil = r_cur[IW];
    assign w_ci      = r_cur[IW-1:0];
    assign w_rearm   = r_periodic[w_ci] && ((r_repeat[w_ci] > 16'sd0) ||
                                            (r_repeat[w_ci] == -16'sd1));
    assign w_walk_on = !w_cur_nil && (r_timeout[w_ci] < r_t);

    // slot index unit: quotient by reciprocal multiply
    logic [25:0]      w_pf;
    logic [32:0]      w_ps;
    logic             w_is_slow;
    logic [SUM_W-1:0] w_sum;
    assign w_pf      = {10'd0, r_t} * 26'(RECIP_100);
    assign w_ps      = {17'd0, r_t} * 33'(RECIP_1000);
    assign w_is_slow = (r_t >= 16'(FAST_LIMIT));
    assign w_sum     = w_is_slow ? (SUM_W'(w_ps[32:SHIFT_1000]) + SUM_W'(r_sp))
                                 : (SUM_W'(w_pf[25:SHIFT_100]) + SUM_W'(r_fp));

    // pointer advance with wrap
    logic [SPW-1:0] w_fp_adv, w_sp_adv;
    assign w_fp_adv = (r_fp == SPW'(SLOTS - 1)) ? '0 : r_fp + 1'b1;
    assign w_sp_adv = (r_sp == SPW'(SLOTS - 1)) ? '0 : r_sp + 1'b1;

    // result emission; drops past the result cap
    logic    w_can, w_emit;
    logic [15:0] w_eid;
    t_status w_est;
    assign w_can = (r_nres == NRES_W'(MAX_RESULTS)) || !r_pv || !r_ov;

    always_comb begin
        w_emit = 1'b0;
        w_eid  = '0;
        w_est  = r_est;
        case (r_state)
            S_FIRE: begin
                w_emit = !w_cur_nil && w_can;
                w_eid  = r_id[w_ci];
                w_est  = ST_FIRED;
            end
            S_EMIT: begin
                w_emit = w_can;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_acc) n_state = i_kind ? S_FIRE_HEAD : (w_full ? S_EMIT : S_CALC);
            S_FIRE_HEAD: n_state = S_FIRE;
            S_FIRE:      if (w_cur_nil) n_state = (r_k != '0) ? S_REARM : S_AFTER;
            S_REARM:     n_state = (r_ri == r_k) ? S_AFTER : S_CALC;
            S_CALC:      n_state = S_MOD;
            S_MOD:       if (r_sum < SUM_W'(SLOTS)) n_state = S_WALK_INIT;
            S_WALK_INIT: n_state = S_WALK;
            S_WALK:      if (!w_walk_on) n_state = r_tick ? S_REARM : S_EMIT;
            S_AFTER: begin
                if (!r_slowph && r_second) n_state = S_FIRE_HEAD;
                else n_state = (r_nres == '0) ? S_EMIT : S_FIN;
            end
            S_EMIT:      if (w_can) n_state = S_FIN;
            S_FIN:       if (!r_ov) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            for (int j = 0; j < 2 * SLOTS; j++) r_head[j] <= NIL;
            r_fp     <= '0;
            r_sp     <= '0;
            r_tc     <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
            r_nres   <= '0;
            r_tick   <= 1'b0;
            r_second <= 1'b0;
            r_slowph <= 1'b0;
            r_k      <= '0;
            r_ri     <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;

            if (w_emit && (r_nres != NRES_W'(MAX_RESULTS))) begin
                if (r_pv) begin
                    r_ov    <= 1'b1;
                    r_oid   <= r_pid;
                    r_ost   <= r_pst;
                    r_olast <= 1'b0;
                end
                r_pv   <= 1'b1;
                r_pid  <= w_eid;
                r_pst  <= w_est;
                r_nres <= r_nres + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_tick <= i_kind;
                        if (i_kind) begin
                            r_slot   <= SXW'(r_fp);
                            r_fp     <= w_fp_adv;
                            r_second <= (r_tc == 4'(TICKS_PER_SEC - 1));
                            r_tc     <= (r_tc == 4'(TICKS_PER_SEC - 1)) ? '0 : r_tc + 1'b1;
                            r_slowph <= 1'b0;
                        end else if (w_full) begin
                            r_est <= ST_FULL;
                        end else begin
                            r_est          <= ST_ADD_OK;
                            r_e            <= w_free;
                            r_t            <= i_timeout_ms;
                            r_valid[w_free] <= 1'b1;
                        end
                    end
                end
                S_FIRE_HEAD: begin
                    r_cur          <= r_head[r_slot];
                    r_head[r_slot] <= NIL;
                    r_k            <= '0;
                    r_ri           <= '0;
                end
                S_FIRE: begin
                    if (!w_cur_nil && w_can) begin
                        if (w_rearm) r_k <= r_k + 1'b1;
                        else r_valid[w_ci] <= 1'b0;
                        r_cur <= r_next[w_ci];
                    end
                end
                S_REARM: begin
                    if (r_ri != r_k) begin
                        r_e  <= r_rq[r_ri[IW-1:0]];
                        r_t  <= r_rqt[r_ri[IW-1:0]];
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_CALC: begin
                    r_sum  <= w_sum;
                    r_slow <= w_is_slow;
                end
                S_MOD: begin
                    if (r_sum >= SUM_W'(SLOTS)) r_sum <= r_sum - SUM_W'(SLOTS);
                    else r_slot <= SXW'(r_sum) + (r_slow ? SXW'(SLOTS) : '0);
                end
                S_WALK_INIT: begin
                    r_cur  <= r_head[r_slot];
                    r_prev <= NIL;
                end
                S_WALK: begin
                    if (w_walk_on) begin
                        r_prev <= r_cur;
                        r_cur  <= r_next[w_ci];
                    end else if (r_prev[IW]) begin
                        r_head[r_slot] <= {1'b0, r_e};
                    end
                end
                S_AFTER: begin
                    if (!r_slowph && r_second) begin
                        r_slowph <= 1'b1;
                        r_sp     <= w_sp_adv;
                        r_slot   <= SXW'(SLOTS) + SXW'(r_sp);
                    end else if (r_nres == '0) begin
                        r_est <= ST_NO_FIRE;
                    end
                end
                S_FIN: begin
                    if (!r_ov) begin
                        r_ov    <= 1'b1;
                        r_oid   <= r_pid;
                        r_ost   <= r_pst;
                        r_olast <= 1'b1;
                        r_pv    <= 1'b0;
                        r_nres  <= '0;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // pool payload and re-arm queue, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc && !i_kind && !w_full) begin
                    r_id[w_free]       <= i_task_id;
                    r_timeout[w_free]  <= i_timeout_ms;
                    r_periodic[w_free] <= i_periodic;
                    r_repeat[w_free]   <= i_repeat_count;
                    r_interval[w_free] <= i_interval_ms;
                end
            end
            S_FIRE: begin
                if (!w_cur_nil && w_can && w_rearm) begin
                    if (r_repeat[w_ci] > 16'sd0) r_repeat[w_ci] <= r_repeat[w_ci] - 16'sd1;
                    r_timeout[w_ci]    <= r_interval[w_ci];
                    r_rq[r_k[IW-1:0]]  <= w_ci;
                    r_rqt[r_k[IW-1:0]] <= r_interval[w_ci];
                end
            end
            S_WALK: begin
                if (!w_walk_on) begin
                    r_next[r_e] <= r_cur;
                    if (!r_prev[IW]) r_next[r_prev[IW-1:0]] <= {1'b0, r_e};
                end
            end
            default: begin
            end
        endcase
    end

    // at most the result cap is counted per transaction
    a_nres_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("result count over cap");

    // idle always means the pending result was handed on
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending result left in idle");

    // re-arm queue never overruns the pool
    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_TASKS))
        else $error("re-arm queue overrun");

    // wheel pointers stay inside the wheel
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fp < SPW'(SLOTS - 1) || r_fp == SPW'(SLOTS - 1)) &&
        (r_sp < SPW'(SLOTS - 1) || r_sp == SPW'(SLOTS - 1)))
        else $error("wheel pointer out of range");
endmodule
`default_nettype wire

FILE: tb/sv/two_level_timing_wheel_chk.sv
// checker for the two-level timing wheel: watches both channels, predicts and compares
`timescale 1ns / 100ps
`default_nettype none
module two_level_timing_wheel_chk
    import tltw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_ready_dut,
    input  wire logic               i_kind,
    input  wire logic [15:0]        i_task_id,
    input  wire logic [15:0]        i_timeout_ms,
    input  wire logic               i_periodic,
    input  wire logic signed [15:0] i_repeat_count,
    input  wire logic [15:0]        i_interval_ms,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [15:0]        i_fired_task_id,
    input  wire logic [1:0]         i_status,
    input  wire logic               i_last,
    output int                      o_fail_count,
    output int                      o_pending
);
    localparam int NT = MAX_TASKS_DEF;
    localparam int NS = SLOTS_DEF;
    localparam logic [4:0] NONE = 5'h1f;

    typedef struct packed {
        logic [15:0] id;
        t_status     status;
        logic        last;
    } t_wheel_result;

    t_wheel_result result_q[$];

    logic               pool_used[NT];
    logic [15:0]        pool_id[NT];
    logic [15:0]        pool_tmo[NT];
    logic [15:0]        pool_ivl[NT];
    int                 pool_rep[NT];
    logic               pool_per[NT];
    logic [4:0]         pool_next[NT];
    logic [4:0]         head[2*NS];
    int                 fast_ptr, slow_ptr, ticks;
    int                 step_n;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic post(input logic [15:0] id, input t_status st);
        t_wheel_result r;
        r.id     = id;
        r.status = st;
        r.last   = 1'b0;
        if (step_n < MAX_RESULTS) begin
            result_q.insert(result_q.size(), r);
            step_n++;
        end
    endtask

    // sorted insert, new entry before equal timeouts
    task automatic file_task(input int e);
        int t, s, prev, cur;
        t = pool_tmo[e];
        if (t < FAST_LIMIT) s = ((t + fast_ptr * 100) / 100) % NS;
        else s = NS + ((t + slow_ptr * 1000) / 1000) % NS;
        prev = -1;
        cur = head[s];
        while (cur != NONE && pool_tmo[cur] < t) begin
            prev = cur;
            cur = pool_next[cur];
        end
        pool_next[e] = cur[4:0];
        if (prev < 0) head[s] = e[4:0];
        else pool_next[prev] = e[4:0];
    endtask

    task automatic fire_slot(input int s);
        int rearm[NT];
        int k, cur, nxt;
        k = 0;
        cur = head[s];
        head[s] = NONE;
        while (cur != NONE) begin
            nxt = pool_next[cur];
            post(pool_id[cur], ST_FIRED);
            if (pool_per[cur] && (pool_rep[cur] > 0 || pool_rep[cur] == -1)) begin
                if (pool_rep[cur] > 0) pool_rep[cur]--;
                pool_tmo[cur] = pool_ivl[cur];
                rearm[k] = cur;
                k++;
            end else begin
                pool_used[cur] = 1'b0;
            end
            cur = nxt;
        end
        for (int i = 0; i < k; i++) file_task(rearm[i]);
    endtask

    task automatic predict_wheel_step();
        int e, fs, ss;
        step_n = 0;
        if (!i_kind) begin
            e = 0;
            while (e < NT && pool_used[e]) e++;
            if (e >= NT) begin
                post(16'd0, ST_FULL);
            end else begin
                pool_used[e] = 1'b1;
                pool_id[e]   = i_task_id;
                pool_tmo[e]  = i_timeout_ms;
                pool_per[e]  = i_periodic;
                pool_rep[e]  = int'(i_repeat_count);
                pool_ivl[e]  = i_interval_ms;
                file_task(e);
                post(16'd0, ST_ADD_OK);
            end
        end else begin
            fs = fast_ptr;
            fast_ptr = (fs + 1) % NS;
            fire_slot(fs);
            ticks++;
            if (ticks >= TICKS_PER_SEC) begin
                ss = slow_ptr;
                ticks = 0;
                slow_ptr = (ss + 1) % NS;
                fire_slot(NS + ss);
            end
            if (step_n == 0) post(16'd0, ST_NO_FIRE);
        end
        result_q[$].last = 1'b1;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        foreach (pool_used[i]) pool_used[i] = 1'b0;
        foreach (head[i]) head[i] = NONE;
        fast_ptr = 0;
        slow_ptr = 0;
        ticks = 0;
    end

    always @(posedge i_clk) begin
        t_wheel_result exp_r;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result id=%0h st=%0d",
                                              i_fired_task_id, i_status));
                end else begin
                    exp_r = result_q.pop_front();
                    if (i_fired_task_id !== exp_r.id)
                        report_mismatch($sformatf("id %0h, want %0h",
                                                  i_fired_task_id, exp_r.id));
                    if (i_status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_status, exp_r.status));
                    if (i_last !== exp_r.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  i_last, exp_r.last));
                end
            end
            if (i_valid && i_ready_dut) predict_wheel_step();
        end
        o_pending = result_q.size();
    end
endmodule
`default_nettype wire

FILE: tb/sv/two_level_timing_wheel_tb.sv
// testbench top for the two-level timing wheel: stimulus, handshakes and verdict
`timescale 1ns / 100ps
`default_nettype none
module two_level_timing_wheel_tb;
    import tltw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = KIND_ADD;
    logic [15:0]        task_id = '0;
    logic [15:0]        timeout_ms = '0;
    logic               periodic = 1'b0;
    logic signed [15:0] repeat_count = '0;
    logic [15:0]        interval_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        fired_task_id;
    logic [1:0]         status;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 hold_off = 1'b0;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    two_level_timing_wheel i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_kind(kind), .i_task_id(task_id), .i_timeout_ms(timeout_ms),
        .i_periodic(periodic), .i_repeat_count(repeat_count),
        .i_interval_ms(interval_ms),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_fired_task_id(fired_task_id), .o_status(status), .o_last(last)
    );

    two_level_timing_wheel_chk i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_dut(in_ready),
        .i_kind(kind), .i_task_id(task_id), .i_timeout_ms(timeout_ms),
        .i_periodic(periodic), .i_repeat_count(repeat_count),
        .i_interval_ms(interval_ms),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_fired_task_id(fired_task_id), .i_status(status), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // present one transaction and hold it until accepted; valid drops only for a gap
    task automatic send_item(input logic k, input logic [15:0] id,
                             input logic [15:0] tmo, input logic per,
                             input logic [15:0] rep, input logic [15:0] ivl);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        kind         <= k;
        task_id      <= id;
        timeout_ms   <= tmo;
        periodic     <= per;
        repeat_count <= rep;
        interval_ms  <= ivl;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // random add biased toward near timeouts so tasks actually fire
    task automatic send_random_add();
        logic [15:0] tmo, ivl, rep;
        case ($urandom_range(0, 3))
            0: tmo = 16'($urandom_range(0, 999));
            1: tmo = 16'($urandom_range(1000, 9999));
            2: tmo = 16'($urandom);
            default: tmo = 16'($urandom_range(0, 300));
        endcase
        ivl = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
        case ($urandom_range(0, 4))
            0: rep = 16'hffff;
            1: rep = 16'($urandom);
            2: rep = 16'h8000 | 16'($urandom_range(0, 5));
            default: rep = 16'($urandom_range(0, 4));
        endcase
        send_item(KIND_ADD, 16'($urandom), tmo, 1'($urandom), rep, ivl);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int g;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles in which neither channel completes a handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick on empty, extremes of fields, full pool, overflow of results
        send_tick();
        send_item(KIND_ADD, 16'hffff, 16'd0, 1'b1, 16'hffff, 16'd0);     // forever, zero interval
        send_item(KIND_ADD, 16'h0000, 16'd999, 1'b0, 16'h7fff, 16'hffff);
        send_item(KIND_ADD, 16'h1234, 16'd1000, 1'b1, 16'h8000, 16'd50); // below -1
        send_item(KIND_ADD, 16'h5555, 16'hffff, 1'b1, 16'd2, 16'd1000);
        send_item(KIND_ADD, 16'haaaa, 16'd0, 1'b1, 16'd1, 16'd0);        // equal timeout
        send_tick();
        send_tick();
        // fill the pool: same-slot tasks that fire on the tenth tick and re-arm
        // into the slow slot firing in that tick, then a rejected add
        for (int i = 0; i < 13; i++)
            send_item(KIND_ADD, 16'(16'h100 + i), 16'd600, 1'b1, 16'd1, 16'd10000);
        send_item(KIND_ADD, 16'hdead, 16'd5, 1'b0, 16'd0, 16'd0);
        // ten ticks: overflowing fast slot and slow slot with rearm into current slow slot
        for (int i = 0; i < 10; i++) send_tick();

        // random part, with one long receiver hold-off while ticks keep coming
        for (int n = 0; n < 100; n++) begin
            if (n == 60) hold_off = 1'b1;
            if ($urandom_range(0, 1) == 0) send_random_add();
            else send_tick();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/tltw_pkg.sv
rtl/core/two_level_timing_wheel.sv
tb/sv/two_level_timing_wheel_chk.sv
tb/sv/two_level_timing_wheel_tb.sv
